// ----- src/triangle_face_normal_jacobian_unit_assert.svh -----
// assertion macros used by the checker file tfnj_checker.sv
`ifndef TRIANGLE_FACE_NORMAL_JACOBIAN_UNIT_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_JACOBIAN_UNIT_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define TFNJ_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored while reset is high
`define TFNJ_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// what must hold in the cycle after reset
`define TFNJ_ASSERT_RST(lbl, cons, msg) \
   lbl: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// ----- src/tfnj_pkg.sv -----
// ----------------------------------------------------------------------------
// tfnj_pkg
// types and fixed widths of the triangle face normal and jacobian unit
// ----------------------------------------------------------------------------
package tfnj_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int NORMAL_W    = 16;
   localparam int JAC_W       = 32;
   localparam int EDGE_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = 2 * EDGE_W;
   localparam int CROSS_W     = PROD_W + 1;
   localparam int MAG_W       = PROD_W;
   localparam int JAC_MAG_W   = 34;
   localparam int SQRT_ROOT_W = 35;
   localparam int SQRT_RAD_W  = 2 * SQRT_ROOT_W;
   localparam int SQRT_REM_W  = SQRT_ROOT_W + 2;
   localparam int MANT_W      = 31;
   localparam int NROOT_W     = 32;

   // faces 0 and 2 carry a negative sign
   localparam logic [3:0] FACE_SIGN_NEG = 4'b0101;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [NORMAL_W-1:0] normal_type;

   typedef struct packed {
      coord_type  a_x;
      coord_type  a_y;
      coord_type  a_z;
      coord_type  b_x;
      coord_type  b_y;
      coord_type  b_z;
      coord_type  c_x;
      coord_type  c_y;
      coord_type  c_z;
      logic       orientation_negative;
      logic [1:0] face_index;
   } req_type;

   typedef struct packed {
      normal_type       normal_x;
      normal_type       normal_y;
      normal_type       normal_z;
      logic [JAC_W-1:0] jacobian;
      logic             degenerate;
   } rsp_type;

   typedef struct packed {
      logic [SQRT_RAD_W-1:0]  rad;
      logic [SQRT_REM_W-1:0]  rem;
      logic [SQRT_ROOT_W-1:0] root;
   } sqrt_state_type;

endpackage

// ----- src/triangle_face_normal_jacobian_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_face_normal_jacobian_unit
// unit normal and face jacobian, one tetrahedron face per unstalled clock
// ----------------------------------------------------------------------------
// takes one face per cycle while req_stall is low and returns one result per
// face, in order. the path from input transfer to result runs through nine
// front stages, two side-by-side rows of 35 square root cells, one numerator
// stage, NORMAL_FRAC_BITS + 1 divider cells and the output register. a skid
// register behind the output lets one more face be accepted when the consumer
// first stalls; req_stall is raised only while the skid register is occupied.
// a zero-length face returns degenerate = 1 with zero normal and zero
// jacobian.
// ----------------------------------------------------------------------------
module triangle_face_normal_jacobian_unit import tfnj_pkg::*; #(
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int QUO_W   = NORMAL_FRAC_BITS + 1;
   localparam int NUM_W   = MANT_W + NORMAL_FRAC_BITS + 1;
   localparam int BLEN_W  = $clog2(MAG_W + 1);
   localparam int ALIGN_W = (MAG_W > MANT_W) ? MAG_W : MANT_W;
   localparam int SH_W    = $clog2(ALIGN_W + 1);
   localparam int JSQ_W   = 2 * JAC_MAG_W;
   localparam int CSQ_W   = 2 * MANT_W;
   localparam int SN_W    = NORMAL_FRAC_BITS + 2;

   typedef struct packed {
      logic [2:0][MANT_W-1:0] c;
      logic [2:0]             neg;
      logic                   neg_all;
      logic                   deg;
      logic                   jsat;
   } side_a_type;

   typedef struct packed {
      logic [2:0]       neg;
      logic             neg_all;
      logic             deg;
      logic [JAC_W-1:0] jac;
   } side_b_type;

   // output and skid register valid flags
   logic rsp_valid_ff, skid_valid_ff;

   // global advance: the pipeline moves whenever the skid register is free
   logic en;
   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // stage 1: input register
   logic    v1_ff;
   req_type r1_ff;

   // stage 2: edge vectors from the first vertex
   logic                     v2_ff, na2_ff;
   logic signed [EDGE_W-1:0] e2_ff [3];
   logic signed [EDGE_W-1:0] f2_ff [3];

   // stage 3: the six products of the cross product
   logic                     v3_ff, na3_ff;
   logic signed [PROD_W-1:0] pr3_ff [6];

   // stage 4: cross product
   logic                      v4_ff, na4_ff;
   logic signed [CROSS_W-1:0] p4_ff [3];

   // stage 5: magnitudes and signs
   logic             v5_ff, na5_ff, deg5_ff;
   logic [2:0]       neg5_ff;
   logic [MAG_W-1:0] m5_ff [3];

   // stage 6: bit length of the largest magnitude
   logic              v6_ff, na6_ff, deg6_ff;
   logic [2:0]        neg6_ff;
   logic [MAG_W-1:0]  m6_ff [3];
   logic [BLEN_W-1:0] b6_ff;

   // stage 7: normalised mantissas and jacobian squares
   logic              v7_ff;
   side_a_type        sa7_ff;
   logic [JSQ_W-1:0]  jsq7_ff [3];

   // stage 8: mantissa squares and jacobian sum
   logic                  v8_ff;
   side_a_type            sa8_ff;
   logic [CSQ_W-1:0]      csq8_ff [3];
   logic [SQRT_RAD_W-1:0] jsum8_ff;

   // stage 9: radicands of both roots
   logic                  v9_ff;
   side_a_type            sa9_ff;
   logic [SQRT_RAD_W-1:0] nsum9_ff;
   logic [SQRT_RAD_W-1:0] jsum9_ff;

   // front stage next values
   logic signed [EDGE_W-1:0]  e2_in [3];
   logic signed [EDGE_W-1:0]  f2_in [3];
   logic                      na2_in;
   logic signed [PROD_W-1:0]  pr3_in [6];
   logic signed [CROSS_W-1:0] p4_in [3];
   logic [MAG_W-1:0]          m5_in [3];
   logic [2:0]                neg5_in;
   logic [MAG_W-1:0]          or_m6;
   logic [BLEN_W-1:0]         b6_in;
   logic [SH_W-1:0]           sh7;
   logic [ALIGN_W-1:0]        al7 [3];
   logic [JAC_MAG_W-1:0]      mj7 [3];
   side_a_type                sa7_in;
   logic [JSQ_W-1:0]          jsq7_in [3];
   logic [CSQ_W-1:0]          csq8_in [3];
   logic [SQRT_RAD_W-1:0]     jsum8_in;
   logic [SQRT_RAD_W-1:0]     nsum9_in;

   always_comb begin
      // edges b - a and c - a
      e2_in[0] = EDGE_W'(r1_ff.b_x) - EDGE_W'(r1_ff.a_x);
      e2_in[1] = EDGE_W'(r1_ff.b_y) - EDGE_W'(r1_ff.a_y);
      e2_in[2] = EDGE_W'(r1_ff.b_z) - EDGE_W'(r1_ff.a_z);
      f2_in[0] = EDGE_W'(r1_ff.c_x) - EDGE_W'(r1_ff.a_x);
      f2_in[1] = EDGE_W'(r1_ff.c_y) - EDGE_W'(r1_ff.a_y);
      f2_in[2] = EDGE_W'(r1_ff.c_z) - EDGE_W'(r1_ff.a_z);
      // orientation sign combined with the face sign
      na2_in = r1_ff.orientation_negative ^ FACE_SIGN_NEG[r1_ff.face_index];

      pr3_in[0] = e2_ff[1] * f2_ff[2];
      pr3_in[1] = e2_ff[2] * f2_ff[1];
      pr3_in[2] = e2_ff[2] * f2_ff[0];
      pr3_in[3] = e2_ff[0] * f2_ff[2];
      pr3_in[4] = e2_ff[0] * f2_ff[1];
      pr3_in[5] = e2_ff[1] * f2_ff[0];

      for (int i = 0; i < 3; i++) begin
         p4_in[i] = CROSS_W'(pr3_ff[2*i]) - CROSS_W'(pr3_ff[2*i+1]);
      end

      for (int i = 0; i < 3; i++) begin
         neg5_in[i] = p4_ff[i][CROSS_W-1];
         m5_in[i]   = neg5_in[i] ? MAG_W'(-p4_ff[i]) : MAG_W'(p4_ff[i]);
      end

      // bit length of the largest magnitude equals that of the or of all three
      or_m6 = m5_ff[0] | m5_ff[1] | m5_ff[2];
      b6_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (or_m6[i]) begin
            b6_in = BLEN_W'(i + 1);
         end
      end

      // left-align so the leading one of the largest lands at the mantissa top
      sh7 = SH_W'(ALIGN_W) - SH_W'(b6_ff);
      sa7_in.neg     = neg6_ff;
      sa7_in.neg_all = na6_ff;
      sa7_in.deg     = deg6_ff;
      sa7_in.jsat    = 1'b0;
      for (int i = 0; i < 3; i++) begin
         al7[i]      = ALIGN_W'(m6_ff[i]) << sh7;
         sa7_in.c[i] = al7[i][ALIGN_W-1 -: MANT_W];
         mj7[i]      = JAC_MAG_W'(m6_ff[i]);
         jsq7_in[i]  = mj7[i] * mj7[i];
         // a face this large saturates the jacobian
         if ((m6_ff[i] >> JAC_MAG_W) != '0) begin
            sa7_in.jsat = 1'b1;
         end
      end

      for (int i = 0; i < 3; i++) begin
         csq8_in[i] = sa7_ff.c[i] * sa7_ff.c[i];
      end
      jsum8_in = SQRT_RAD_W'(jsq7_ff[0]) + SQRT_RAD_W'(jsq7_ff[1])
               + SQRT_RAD_W'(jsq7_ff[2]);

      nsum9_in = SQRT_RAD_W'(csq8_ff[0]) + SQRT_RAD_W'(csq8_ff[1])
               + SQRT_RAD_W'(csq8_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_ff    <= req_data;
         e2_ff    <= e2_in;
         f2_ff    <= f2_in;
         na2_ff   <= na2_in;
         pr3_ff   <= pr3_in;
         na3_ff   <= na2_ff;
         p4_ff    <= p4_in;
         na4_ff   <= na3_ff;
         m5_ff    <= m5_in;
         neg5_ff  <= neg5_in;
         na5_ff   <= na4_ff;
         deg5_ff  <= (m5_in[0] | m5_in[1] | m5_in[2]) == '0;
         m6_ff    <= m5_ff;
         neg6_ff  <= neg5_ff;
         na6_ff   <= na5_ff;
         deg6_ff  <= deg5_ff;
         b6_ff    <= b6_in;
         sa7_ff   <= sa7_in;
         jsq7_ff  <= jsq7_in;
         sa8_ff   <= sa7_ff;
         csq8_ff  <= csq8_in;
         jsum8_ff <= jsum8_in;
         sa9_ff   <= sa8_ff;
         nsum9_ff <= nsum9_in;
         jsum9_ff <= jsum8_ff;
      end
   end

   // two rows of square root cells, jacobian and normal length side by side
   sqrt_state_type jac_st  [SQRT_ROOT_W+1];
   sqrt_state_type norm_st [SQRT_ROOT_W+1];
   side_a_type     sa_ff   [SQRT_ROOT_W];
   logic           va_ff   [SQRT_ROOT_W];

   always_comb begin
      jac_st[0].rad   = jsum9_ff;
      jac_st[0].rem   = '0;
      jac_st[0].root  = '0;
      norm_st[0].rad  = nsum9_ff;
      norm_st[0].rem  = '0;
      norm_st[0].root = '0;
   end

   for (genvar k = 0; k < SQRT_ROOT_W; k++) begin : g_sqrt
      tfnj_sqrt_cell u_jac_cell (
         .clock      (clock),
         .en         (en),
         .prev_state (jac_st[k]),
         .state_ff   (jac_st[k+1])
      );
      tfnj_sqrt_cell u_norm_cell (
         .clock      (clock),
         .en         (en),
         .prev_state (norm_st[k]),
         .state_ff   (norm_st[k+1])
      );
   end

   // side information travels alongside the root cells
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SQRT_ROOT_W; k++) begin
            va_ff[k] <= 1'b0;
         end
      end else if (en) begin
         va_ff[0] <= v9_ff;
         for (int k = 1; k < SQRT_ROOT_W; k++) begin
            va_ff[k] <= va_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff[0] <= sa9_ff;
         for (int k = 1; k < SQRT_ROOT_W; k++) begin
            sa_ff[k] <= sa_ff[k-1];
         end
      end
   end

   // numerator stage: rounded dividend and the finished jacobian
   side_a_type                 sa_last;
   logic [NROOT_W-1:0]         len_root;
   logic [SQRT_ROOT_W-3:0]     jq;
   logic [NUM_W-1:0]           num_in [3];
   side_b_type                 sb0_in;
   logic                       vd_ff;
   logic [NUM_W-1:0]           num_ff [3];
   logic [NROOT_W-1:0]         len_ff;
   side_b_type                 sb0_ff;

   always_comb begin
      sa_last  = sa_ff[SQRT_ROOT_W-1];
      len_root = NROOT_W'(norm_st[SQRT_ROOT_W].root);
      jq       = jac_st[SQRT_ROOT_W].root[SQRT_ROOT_W-1:2];
      for (int i = 0; i < 3; i++) begin
         num_in[i] = (NUM_W'(sa_last.c[i]) << NORMAL_FRAC_BITS)
                   + NUM_W'(len_root >> 1);
      end
      sb0_in.neg     = sa_last.neg;
      sb0_in.neg_all = sa_last.neg_all;
      sb0_in.deg     = sa_last.deg;
      if (sa_last.deg) begin
         sb0_in.jac = '0;
      end else if (sa_last.jsat || ((jq >> JAC_W) != '0)) begin
         sb0_in.jac = '1;
      end else begin
         sb0_in.jac = JAC_W'(jq);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (en) begin
         vd_ff <= va_ff[SQRT_ROOT_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
         len_ff <= len_root;
         sb0_ff <= sb0_in;
      end
   end

   // three divider rows, one per normal component
   logic [NROOT_W-1:0] drem [3][QUO_W+1];
   logic [QUO_W-1:0]   dnq  [3][QUO_W+1];
   logic [NROOT_W-1:0] dden [3][QUO_W+1];
   side_b_type         sb_ff [QUO_W];
   logic               vb_ff [QUO_W];

   for (genvar i = 0; i < 3; i++) begin : g_lane
      assign drem[i][0] = NROOT_W'(num_ff[i] >> QUO_W);
      assign dnq[i][0]  = num_ff[i][QUO_W-1:0];
      assign dden[i][0] = len_ff;
      for (genvar k = 0; k < QUO_W; k++) begin : g_div
         tfnj_div_cell #(
            .DEN_W (NROOT_W),
            .QUO_W (QUO_W)
         ) u_div_cell (
            .clock    (clock),
            .en       (en),
            .prev_rem (drem[i][k]),
            .prev_nq  (dnq[i][k]),
            .prev_den (dden[i][k]),
            .rem_ff   (drem[i][k+1]),
            .nq_ff    (dnq[i][k+1]),
            .den_ff   (dden[i][k+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_W; k++) begin
            vb_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vb_ff[0] <= vd_ff;
         for (int k = 1; k < QUO_W; k++) begin
            vb_ff[k] <= vb_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0] <= sb0_ff;
         for (int k = 1; k < QUO_W; k++) begin
            sb_ff[k] <= sb_ff[k-1];
         end
      end
   end

   // final clamp and sign, feeding the output register
   side_b_type             sb_last;
   logic [QUO_W-1:0]       mag [3];
   logic signed [SN_W-1:0] sn  [3];
   normal_type             nrm [3];
   rsp_type                fin;
   logic                   fin_valid;

   always_comb begin
      sb_last   = sb_ff[QUO_W-1];
      fin_valid = vb_ff[QUO_W-1];
      for (int i = 0; i < 3; i++) begin
         mag[i] = dnq[i][QUO_W];
         if (mag[i] > (QUO_W'(1) << NORMAL_FRAC_BITS)) begin
            mag[i] = QUO_W'(1) << NORMAL_FRAC_BITS;
         end
         sn[i] = signed'({1'b0, mag[i]});
         if (sb_last.neg[i] != sb_last.neg_all) begin
            sn[i] = -sn[i];
         end
         nrm[i] = sb_last.deg ? '0 : NORMAL_W'(sn[i]);
      end
      fin.normal_x   = nrm[0];
      fin.normal_y   = nrm[1];
      fin.normal_z   = nrm[2];
      fin.jacobian   = sb_last.jac;
      fin.degenerate = sb_last.deg;
   end

   // output register with a skid register behind it
   rsp_type rsp_data_ff, skid_data_ff;
   logic    take;

   assign take      = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            rsp_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (fin_valid) begin
         if (!rsp_valid_ff || take) begin
            rsp_data_ff  <= fin;
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_data_ff  <= fin;
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

// ----- src/tfnj_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// tfnj_sqrt_cell
// one root bit of a digit-by-digit integer square root
// ----------------------------------------------------------------------------
module tfnj_sqrt_cell import tfnj_pkg::*; (
   input  logic           clock,
   input  logic           en,
   input  sqrt_state_type prev_state,
   output sqrt_state_type state_ff
);

   localparam int PART_W = SQRT_REM_W + 2;

   sqrt_state_type    state_in;
   logic [PART_W-1:0] part;
   logic [PART_W-1:0] trial;
   logic              fits;

   always_comb begin
      part  = {prev_state.rem, prev_state.rad[SQRT_RAD_W-1 -: 2]};
      trial = PART_W'({prev_state.root, 2'b01});
      fits  = part >= trial;
      state_in.rad  = {prev_state.rad[SQRT_RAD_W-3:0], 2'b00};
      state_in.rem  = fits ? SQRT_REM_W'(part - trial) : SQRT_REM_W'(part);
      state_in.root = {prev_state.root[SQRT_ROOT_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/tfnj_div_cell.sv -----
// ----------------------------------------------------------------------------
// tfnj_div_cell
// one quotient bit of a restoring divider
// ----------------------------------------------------------------------------
module tfnj_div_cell #(
   parameter int DEN_W = 32,
   parameter int QUO_W = 15
) (
   input  logic             clock,
   input  logic             en,
   input  logic [DEN_W-1:0] prev_rem,
   input  logic [QUO_W-1:0] prev_nq,
   input  logic [DEN_W-1:0] prev_den,
   output logic [DEN_W-1:0] rem_ff,
   output logic [QUO_W-1:0] nq_ff,
   output logic [DEN_W-1:0] den_ff
);

   logic [DEN_W:0]   part;
   logic             fits;
   logic [DEN_W-1:0] rem_in;
   logic [QUO_W-1:0] nq_in;

   // numerator bits leave at the top while quotient bits enter at the bottom
   always_comb begin
      part   = {prev_rem, prev_nq[QUO_W-1]};
      fits   = part >= {1'b0, prev_den};
      rem_in = fits ? DEN_W'(part - {1'b0, prev_den}) : DEN_W'(part);
      nq_in  = {prev_nq[QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         nq_ff  <= nq_in;
         den_ff <= prev_den;
      end
   end

endmodule

// ----- src/tfnj_checker.sv -----
// ----------------------------------------------------------------------------
// tfnj_checker
// port-level checks of the triangle face normal and jacobian unit
// ----------------------------------------------------------------------------
`include "triangle_face_normal_jacobian_unit_assert.svh"

module tfnj_checker import tfnj_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   `TFNJ_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `TFNJ_ASSERT_IMP(a_deg_zero, rsp_valid && rsp_data.degenerate, rsp_data.normal_x == 0 && rsp_data.normal_y == 0 && rsp_data.normal_z == 0 && rsp_data.jacobian == 0, "degenerate face with nonzero result")
   `TFNJ_ASSERT_IMP(a_stall_cause, req_stall, rsp_valid, "input stalled with no result waiting")
   `TFNJ_ASSERT_RST(a_reset_idle, !rsp_valid && !req_stall, "not idle after reset")

endmodule

bind triangle_face_normal_jacobian_unit tfnj_checker u_tfnj_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ----- verif/triangle_face_normal_jacobian_unit_tb.sv -----
// ----------------------------------------------------------------------------
// triangle_face_normal_jacobian_unit_tb
// self-checking bench for the face normal and face jacobian unit
// ----------------------------------------------------------------------------
// a table of directed faces comes first. these cover degenerate faces,
// axis-aligned unit faces with every face sign and orientation, and
// coordinate extremes. random faces follow: full-range, small, collinear and
// extreme values. every accepted face gets an expected result, written in the
// table or predicted in the bench, and is compared field by field against the results, which arrive in order. both
// sides idle in random bursts. the sender holds off once until the block
// has drained.
// ----------------------------------------------------------------------------
module triangle_face_normal_jacobian_unit_tb;
   import tfnj_pkg::*;

   localparam int N_RANDOM   = 830;
   localparam int QUIET_FROM = 760;  // no idling from this random face on
   localparam int DRAIN_AT   = 400;  // sender waits for an empty pipe here
   localparam int TAIL_WAIT  = 200;

   typedef struct {
      req_type face;
      bit      typed;   // expected result written in the row
      rsp_type result;
   } face_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   rsp_type      expected_q[$];   // results still owed by the block, oldest first
   face_row_type face_table[$];
   int           error_count;
   bit           quiet;           // stops all idling near the end

   triangle_face_normal_jacobian_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // unit normal and jacobian of one face, worked out with exact integers
   function automatic rsp_type face_normal(req_type f);
      longint      ex, ey, ez, fx, fy, fz;
      longint      p[3];
      logic [63:0] m[3];
      logic [63:0] c[3];
      bit          neg[3];
      bit          flip;
      int          b, bl, i, k;
      logic [127:0] sq;
      logic [63:0] r, cand, s, l, n, lim;
      logic [15:0] nrm[3];
      rsp_type     o;
      ex = longint'(f.b_x) - longint'(f.a_x);
      ey = longint'(f.b_y) - longint'(f.a_y);
      ez = longint'(f.b_z) - longint'(f.a_z);
      fx = longint'(f.c_x) - longint'(f.a_x);
      fy = longint'(f.c_y) - longint'(f.a_y);
      fz = longint'(f.c_z) - longint'(f.a_z);
      flip = f.orientation_negative ^ FACE_SIGN_NEG[f.face_index];
      p[0] = ey * fz - ez * fy;
      p[1] = ez * fx - ex * fz;
      p[2] = ex * fy - ey * fx;
      b = 0;
      for (i = 0; i < 3; i++) begin
         neg[i] = p[i] < 0;
         m[i] = neg[i] ? 64'(-p[i]) : 64'(p[i]);
         bl = 0;
         while (bl < 64 && (m[i] >> bl) != 0) bl++;
         if (bl > b) b = bl;
      end
      o = '0;
      if (b == 0) begin
         o.degenerate = 1'b1;
         return o;
      end
      // jacobian: floor sqrt of the squared length, then a quarter of it
      sq = '0;
      for (i = 0; i < 3; i++) sq += 128'(m[i]) * 128'(m[i]);
      r = 0;
      for (k = 34; k >= 0; k--) begin
         cand = r | (64'd1 << k);
         if (128'(cand) * 128'(cand) <= sq) r = cand;
      end
      r = r >> 2;
      o.jacobian = (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
      // normal: scale so the largest magnitude sits just below 2^31
      s = 0;
      for (i = 0; i < 3; i++) begin
         c[i] = (b > 31) ? (m[i] >> (b - 31)) : (m[i] << (31 - b));
         s += c[i] * c[i];
      end
      l = 0;
      for (k = 31; k >= 0; k--) begin
         cand = l | (64'd1 << k);
         if (cand * cand <= s) l = cand;
      end
      lim = 64'd1 << 14;
      for (i = 0; i < 3; i++) begin
         n = ((c[i] << 14) + (l >> 1)) / l;
         if (n > lim) n = lim;
         if (neg[i] != flip) n = 64'd0 - n;
         nrm[i] = n[15:0];
      end
      o.normal_x = nrm[0];
      o.normal_y = nrm[1];
      o.normal_z = nrm[2];
      return o;
   endfunction

   function automatic req_type make_face(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz, int o, int fi);
      req_type f;
      f.a_x = coord_type'(ax); f.a_y = coord_type'(ay); f.a_z = coord_type'(az);
      f.b_x = coord_type'(bx); f.b_y = coord_type'(by); f.b_z = coord_type'(bz);
      f.c_x = coord_type'(cx); f.c_y = coord_type'(cy); f.c_z = coord_type'(cz);
      f.orientation_negative = 1'(o);
      f.face_index = 2'(fi);
      return f;
   endfunction

   function automatic rsp_type make_result(int nx, int ny, int nz, longint jac, int degen);
      rsp_type r;
      r.normal_x = normal_type'(nx);
      r.normal_y = normal_type'(ny);
      r.normal_z = normal_type'(nz);
      r.jacobian = 32'(jac);
      r.degenerate = 1'(degen);
      return r;
   endfunction

   function automatic int rand_coord();
      return int'($urandom_range(65535)) - 32768;
   endfunction

   function automatic int rand_extreme();
      int v;
      v = $urandom_range(2);
      return (v == 0) ? -32768 : (v == 1) ? 32767 : 0;
   endfunction

   function automatic req_type random_face(int kind);
      req_type f;
      int      ax, ay, az, dx, dy, dz;
      f = make_face(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    $urandom_range(1), $urandom_range(3));
      if (kind < 15) begin
         // small faces, short edges
         f = make_face(int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64,
                       int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64,
                       int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64,
                       int'($urandom_range(128)) - 64, int'($urandom_range(128)) - 64,
                       int'($urandom_range(128)) - 64, $urandom_range(1),
                       $urandom_range(3));
      end else if (kind < 25) begin
         // collinear vertices, zero-length cross product
         ax = int'($urandom_range(32000)) - 16000;
         ay = int'($urandom_range(32000)) - 16000;
         az = int'($urandom_range(32000)) - 16000;
         dx = int'($urandom_range(10000)) - 5000;
         dy = int'($urandom_range(10000)) - 5000;
         dz = int'($urandom_range(10000)) - 5000;
         f = make_face(ax, ay, az, ax + dx, ay + dy, az + dz, ax + 2 * dx, ay + 2 * dy,
                       az + 2 * dz, $urandom_range(1), $urandom_range(3));
      end else if (kind < 30) begin
         f = make_face(rand_extreme(), rand_extreme(), rand_extreme(), rand_extreme(),
                       rand_extreme(), rand_extreme(), rand_extreme(), rand_extreme(),
                       rand_extreme(), $urandom_range(1), $urandom_range(3));
      end
      return f;
   endfunction

   task automatic check_result(rsp_type got, rsp_type want);
      if (got.normal_x !== want.normal_x) begin
         $error("normal_x expected %0d got %0d", want.normal_x, got.normal_x);
         error_count++;
      end
      if (got.normal_y !== want.normal_y) begin
         $error("normal_y expected %0d got %0d", want.normal_y, got.normal_y);
         error_count++;
      end
      if (got.normal_z !== want.normal_z) begin
         $error("normal_z expected %0d got %0d", want.normal_z, got.normal_z);
         error_count++;
      end
      if (got.jacobian !== want.jacobian) begin
         $error("jacobian expected %0d got %0d", want.jacobian, got.jacobian);
         error_count++;
      end
      if (got.degenerate !== want.degenerate) begin
         $error("degenerate expected %0d got %0d", want.degenerate, got.degenerate);
         error_count++;
      end
   endtask

   // present one face and hold it until the transfer happens
   task automatic send_face(req_type f, bit typed, rsp_type want);
      int gap;
      if (!quiet && $urandom_range(3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(typed ? want : face_normal(f));
   endtask

   // result side: stall in random bursts, check every transfer
   int stall_left;
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(5) == 0) begin
         stall_left <= $urandom_range(0, 10);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $error("result transfer with no face outstanding");
            error_count++;
         end else begin
            check_result(rsp_data, expected_q.pop_front());
         end
      end
   end

   // hard stop in case the block hangs
   initial begin
      #(20 * 400000);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int      i;
      int      waited;
      rsp_type none;
      error_count = 0;
      quiet       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      none        = '0;

      // degenerate faces give all-zero results
      face_table.push_back('{make_face(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                             make_result(0, 0, 0, 0, 1)});
      face_table.push_back('{make_face(32767, -32768, 32767, 32767, -32768, 32767,
                                       32767, -32768, 32767, 1, 3), 1,
                             make_result(0, 0, 0, 0, 1)});
      face_table.push_back('{make_face(0, 0, 0, 1, 1, 1, 2, 2, 2, 0, 1), 1,
                             make_result(0, 0, 0, 0, 1)});
      // unit face in the xy plane, every face sign and orientation
      for (i = 0; i < 8; i++) begin
         face_table.push_back('{make_face(0, 0, 0, 4096, 0, 0, 0, 4096, 0, i[2], i[1:0]), 1,
                                make_result(0, 0,
                                            ((i[2] ^ FACE_SIGN_NEG[i[1:0]]) ? -16384 : 16384),
                                            64'd1 << 22, 0)});
      end
      // coordinate extremes and mixed signs, predicted
      face_table.push_back('{make_face(-32768, -32768, -32768, 32767, -32768, -32768,
                                       -32768, 32767, -32768, 0, 1), 0, none});
      face_table.push_back('{make_face(32767, 32767, 32767, -32768, 32767, 32767,
                                       32767, -32768, 32767, 1, 0), 0, none});
      face_table.push_back('{make_face(-32768, 32767, -32768, 32767, -32768, 32767,
                                       32767, 32767, -32768, 0, 2), 0, none});
      face_table.push_back('{make_face(0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 1), 0, none});
      face_table.push_back('{make_face(0, 0, 0, 1, 2, 3, -3, 1, 2, 0, 3), 0, none});
      face_table.push_back('{make_face(-32768, 0, 32767, 32767, -32768, 0, 0, 32767,
                                       -32768, 1, 2), 0, none});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (face_table[j]) send_face(face_table[j].face, face_table[j].typed,
                                        face_table[j].result);

      for (i = 0; i < N_RANDOM; i++) begin
         if (i == QUIET_FROM) quiet = 1'b1;
         if (i == DRAIN_AT) begin
            // hold off until every outstanding result has come back
            req_valid <= 1'b0;
            @(posedge clock);
            while (expected_q.size() != 0) @(posedge clock);
         end
         send_face(random_face($urandom_range(99)), 0, none);
      end
      req_valid <= 1'b0;

      waited = 0;
      while (expected_q.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_WAIT) @(posedge clock);

      if (error_count == 0 && expected_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         if (expected_q.size() != 0)
            $error("%0d results never arrived", expected_q.size());
         $display("Verification failed");
      end
      $finish;
   end

endmodule
